// File: rtl/core/osc11_pkg.sv
package osc11_pkg;

  // Digits allowed in one color component
  localparam int unsigned MAX_HEX_DIGITS = 4;

  // Prefix positions: 0..7 walk ESC ]11;rgb, then the choice byte
  localparam logic [3:0] POS_CHOICE  = 4'd8;
  localparam logic [3:0] POS_AFTER_A = 4'd9;
  localparam logic [3:0] POS_BODY    = 4'd10;

  // Threshold 0.5 in the scale of the weighted sum (weights per mille, Q0.16)
  localparam logic [25:0] HALF_SCALE = 26'd32767500;

  // floor(v/273) for v < 4096 as (v * 3841) >> 20
  localparam logic [11:0] DIV273_RECIP = 12'd3841;
  localparam int unsigned DIV273_SHIFT = 20;

  // Reply characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_A     = 8'h61;

  // Result codes
  localparam logic [1:0] BG_UNKNOWN = 2'd0;
  localparam logic [1:0] BG_DARK    = 2'd1;
  localparam logic [1:0] BG_LIGHT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SCALE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic consume;   // an input transaction completes this cycle
    logic div;       // load the divide-by-273 quotient
    logic scale;     // load the Q0.16 component
    logic mul;       // load weight times component
    logic acc;       // add product, step to next component
    logic set_good;  // record that the reply is well formed
    logic load_out;  // write the result register, clear parse state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slash_finish;  // current byte is a '/' that closes a component
    logic final_ok;      // reply is complete and well formed
    logic out_free;      // result register can take a value this cycle
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic [7:0] lead_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h1B;
      3'd1:    b = 8'h5D;
      3'd2:    b = 8'h31;
      3'd3:    b = 8'h31;
      3'd4:    b = 8'h3B;
      3'd5:    b = 8'h72;
      3'd6:    b = 8'h67;
      3'd7:    b = 8'h62;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Luma weights per mille; alpha carries no weight
  function automatic logic [9:0] comp_weight(input logic [1:0] idx);
    logic [9:0] w;
    case (idx)
      2'd0:    w = 10'd299;
      2'd1:    w = 10'd587;
      2'd2:    w = 10'd114;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/core/osc11_ctrl.sv
module osc11_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  input  osc11_pkg::status_t status,
  output logic              in_ready,
  output osc11_pkg::cmd_t    cmd
);

  osc11_pkg::state_t state_r, state_nxt;
  logic              last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osc11_pkg::ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      osc11_pkg::ST_IDLE: begin
        if (in_fire) begin
          last_nxt = in_last;
          if (in_last) begin
            state_nxt = osc11_pkg::ST_CHECK;
          end else if (status.slash_finish) begin
            state_nxt = osc11_pkg::ST_DIV;
          end
        end
      end
      osc11_pkg::ST_CHECK: begin
        state_nxt = status.final_ok ? osc11_pkg::ST_DIV : osc11_pkg::ST_EMIT;
      end
      osc11_pkg::ST_DIV:   state_nxt = osc11_pkg::ST_SCALE;
      osc11_pkg::ST_SCALE: state_nxt = osc11_pkg::ST_MUL;
      osc11_pkg::ST_MUL:   state_nxt = osc11_pkg::ST_ACC;
      osc11_pkg::ST_ACC: begin
        state_nxt = last_r ? osc11_pkg::ST_EMIT : osc11_pkg::ST_IDLE;
      end
      osc11_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = osc11_pkg::ST_IDLE;
          last_nxt  = 1'b0;
        end
      end
      default: state_nxt = osc11_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      osc11_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.consume = in_fire;
      end
      osc11_pkg::ST_CHECK: cmd.set_good = status.final_ok;
      osc11_pkg::ST_DIV:   cmd.div      = 1'b1;
      osc11_pkg::ST_SCALE: cmd.scale    = 1'b1;
      osc11_pkg::ST_MUL:   cmd.mul      = 1'b1;
      osc11_pkg::ST_ACC:   cmd.acc      = 1'b1;
      osc11_pkg::ST_EMIT:  cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/osc11_dp.sv
module osc11_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  osc11_pkg::cmd_t    cmd,
  input  logic [7:0]        in_byte,
  input  logic              out_ready,
  output osc11_pkg::status_t status,
  output logic              out_valid,
  output logic [1:0]        out_background
);

  // Parse state
  logic [3:0]  pos_r,    pos_nxt;
  logic        alpha_r,  alpha_nxt;
  logic [1:0]  idx_r,    idx_nxt;
  logic [2:0]  dc_r,     dc_nxt;
  logic [15:0] val_r,    val_nxt;
  logic [25:0] sum_r,    sum_nxt;
  logic        failed_r, failed_nxt;
  logic        good_r,   good_nxt;

  // Scaling pipeline
  logic [3:0]  quot_r;
  logic [15:0] scaled_r;
  logic [25:0] prod_r;

  // Result register
  logic        out_valid_r;
  logic [1:0]  out_bg_r;

  osc11_pkg::hex_t hex;
  logic [1:0]      final_idx;
  logic            is_body;
  logic [23:0]     div_prod;
  logic [15:0]     scaled_nxt;
  logic [1:0]      verdict;

  assign hex       = osc11_pkg::hex_decode(in_byte);
  assign final_idx = alpha_r ? 2'd3 : 2'd2;
  assign is_body   = (pos_r >= osc11_pkg::POS_BODY);

  assign status.slash_finish = !failed_r && is_body && (in_byte == osc11_pkg::CH_SLASH) &&
                               (dc_r != 3'd0) && (idx_r < final_idx);
  assign status.final_ok     = !failed_r && (pos_r == osc11_pkg::POS_BODY) &&
                               (idx_r == final_idx) && (dc_r != 3'd0);
  assign status.out_free     = !out_valid_r || out_ready;

  // Parse-state update
  always_comb begin
    pos_nxt    = pos_r;
    alpha_nxt  = alpha_r;
    idx_nxt    = idx_r;
    dc_nxt     = dc_r;
    val_nxt    = val_r;
    sum_nxt    = sum_r;
    failed_nxt = failed_r;
    good_nxt   = good_r;
    if (cmd.consume && !failed_r) begin
      if (pos_r < osc11_pkg::POS_CHOICE) begin
        if (in_byte == osc11_pkg::lead_byte(pos_r[2:0])) begin
          pos_nxt = pos_r + 4'd1;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (pos_r == osc11_pkg::POS_CHOICE) begin
        if (in_byte == osc11_pkg::CH_COLON) begin
          pos_nxt = osc11_pkg::POS_BODY;
        end else if (in_byte == osc11_pkg::CH_A) begin
          alpha_nxt = 1'b1;
          pos_nxt   = osc11_pkg::POS_AFTER_A;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (pos_r == osc11_pkg::POS_AFTER_A) begin
        if (in_byte == osc11_pkg::CH_COLON) begin
          pos_nxt = osc11_pkg::POS_BODY;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (hex.valid) begin
        if (dc_r >= 3'(osc11_pkg::MAX_HEX_DIGITS)) begin
          failed_nxt = 1'b1;
        end else begin
          val_nxt = {val_r[11:0], hex.value};
          dc_nxt  = dc_r + 3'd1;
        end
      end else if (!status.slash_finish) begin
        // any other byte fails; a closing '/' passes, and its component is added in by the steps that follow
        failed_nxt = 1'b1;
      end
    end
    if (cmd.set_good) begin
      good_nxt = 1'b1;
    end
    if (cmd.acc) begin
      sum_nxt = sum_r + prod_r;
      idx_nxt = idx_r + 2'd1;
      dc_nxt  = 3'd0;
      val_nxt = 16'd0;
    end
    if (cmd.load_out) begin
      pos_nxt    = '0;
      alpha_nxt  = 1'b0;
      idx_nxt    = '0;
      dc_nxt     = '0;
      val_nxt    = '0;
      sum_nxt    = '0;
      failed_nxt = 1'b0;
      good_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      alpha_r  <= 1'b0;
      idx_r    <= '0;
      dc_r     <= '0;
      val_r    <= '0;
      sum_r    <= '0;
      failed_r <= 1'b0;
      good_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      alpha_r  <= alpha_nxt;
      idx_r    <= idx_nxt;
      dc_r     <= dc_nxt;
      val_r    <= val_nxt;
      sum_r    <= sum_nxt;
      failed_r <= failed_nxt;
      good_r   <= good_nxt;
    end
  end

  // Three-digit case: v*65535/4095 = 16v + floor(v/273)
  assign div_prod = 24'(val_r[11:0]) * 24'(osc11_pkg::DIV273_RECIP);

  // Q0.16 scaling by digit count: one- and two-digit components replicate their digits, three use the quotient
  always_comb begin
    case (dc_r)
      3'd0, 3'd1: scaled_nxt = {4{val_r[3:0]}};
      3'd2:       scaled_nxt = {2{val_r[7:0]}};
      3'd3:       scaled_nxt = {val_r[11:0], quot_r};
      default:    scaled_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      quot_r <= div_prod[osc11_pkg::DIV273_SHIFT +: 4];
    end
    if (cmd.scale) begin
      scaled_r <= scaled_nxt;
    end
    if (cmd.mul) begin
      prod_r <= 26'(osc11_pkg::comp_weight(idx_r)) * 26'(scaled_r);
    end
  end

  // Result register
  always_comb begin
    if (!good_r) begin
      verdict = osc11_pkg::BG_UNKNOWN;
    end else if (sum_r < osc11_pkg::HALF_SCALE) begin
      verdict = osc11_pkg::BG_DARK;
    end else begin
      verdict = osc11_pkg::BG_LIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bg_r <= verdict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_background = out_bg_r;

endmodule

// File: rtl/core/osc11_background_classifier.sv
// Channel   Dir  Ports                                  Transaction
// in        in   in_tvalid/in_tready/in_tdata/in_tlast  one reply byte, in_tlast on the final byte
// out       out  out_tvalid/out_tready/out_tdata        one verdict per reply
//
// A plain byte is taken in the idle state. A '/' that closes a component sends it
// through a divide, scale, multiply and accumulate step, one register each. The final
// byte is checked; a malformed reply goes to emit, a well-formed one first runs these steps.
// Reset (rst_n low, synchronous) clears the parser and drops any pending result.
// A result waiting on out_tready does not block bytes of the next reply; only the
// next reply's verdict waits in the emit step, and no byte is taken meanwhile.
module osc11_background_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_req
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] background, [7:2] zero
);

  osc11_pkg::cmd_t    cmd;
  osc11_pkg::status_t status;
  logic               in_fire;
  logic [1:0]         background;

  assign in_fire = in_tvalid && in_tready;

  osc11_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_last  (in_tlast),
    .status   (status),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  osc11_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_byte        (in_tdata),
    .out_ready      (out_tready),
    .status         (status),
    .out_valid      (out_tvalid),
    .out_background (background)
  );

  assign out_tdata = {6'd0, background};

  // Checks

  // right after the final byte, in_tready is low and no further byte is taken
  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> !in_tready)
    else $error("byte accepted right after final byte");

  // the result register is only written when it is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("result written over a pending result");

  // accumulate always follows the multiply step
  a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> $past(cmd.mul))
    else $error("accumulate without product");

  // only the three defined codes ever leave
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined background code");

endmodule
